### sv/ccegen_pkg.sv
// ----------------------------------------------------------------------------
// ccegen_pkg
// shared types and constants of the controller change event generator
// ----------------------------------------------------------------------------
package ccegen_pkg;

  localparam int unsigned AxisSlots   = 7;
  localparam int unsigned ButtonSlots = 32;
  localparam int unsigned AxisCount   = 7;
  localparam int unsigned ButtonCount = 32;

  localparam int unsigned AxisW  = 16;
  localparam int unsigned KindW  = 2;
  localparam int unsigned IndexW = 5;
  localparam int unsigned ValueW = 16;

  typedef enum logic [KindW-1:0] {
    KindConnect    = 2'd0,
    KindDisconnect = 2'd1,
    KindAxis       = 2'd2,
    KindButton     = 2'd3
  } event_kind_e;

  typedef logic [AxisW-1:0] axis_t;

endpackage

### sv/controller_change_event_generator.sv
// ----------------------------------------------------------------------------
// controller_change_event_generator
// turns game controller poll snapshots into connect, disconnect, axis and
// button change events, at most one per poll
// ----------------------------------------------------------------------------
// usage:
//   input channel: one poll beat (valid flag, seven axes, 32 buttons) is taken
//   when in_valid_i is high and in_stall_o is low
//   output channel: one event beat (kind, index, value) is delivered when
//   out_valid_o is high and out_stall_i is low; a poll with nothing to report
//   gives no beat
//   path: an accepted poll is taken into the input register, and the
//   event register loads from it when the poll advances out of the input
//   register with an event to report
//   throughput: one poll per cycle unless an event beat is held; the
//   combinational compare and priority logic between input and event
//   register updates the stored snapshot as the poll leaves the input register
//   stall: a held event beat keeps its payload; polls that yield no event
//   still drain, and one that yields an event waits in the input register
//   with in_stall_o high
//   reset: link is down, stored axes and buttons are zero, both registers
//   are empty
// ----------------------------------------------------------------------------
module controller_change_event_generator
  import ccegen_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        poll_valid_i,
  input  logic [15:0] axis_x_i,
  input  logic [15:0] axis_y_i,
  input  logic [15:0] axis_z_i,
  input  logic [15:0] axis_r_i,
  input  logic [15:0] axis_u_i,
  input  logic [15:0] axis_v_i,
  input  logic [15:0] hat_angle_i,
  input  logic [31:0] button_bits_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [4:0]  event_index_o,
  output logic [15:0] event_value_o
);

  // input register
  logic                   s1_valid_q;
  logic                   poll_valid_q;
  axis_t                  axis_q [AxisSlots];
  logic [ButtonSlots-1:0] button_q;

  // stored snapshot
  logic                   link_up_q, link_up_d;
  axis_t                  axis_store_q [AxisSlots];
  axis_t                  axis_store_d [AxisSlots];
  logic [ButtonSlots-1:0] button_store_q, button_store_d;

  // event register
  logic                   out_valid_q, out_valid_d;
  event_kind_e            kind_q, kind_d;
  logic [IndexW-1:0]      index_q, index_d;
  logic [ValueW-1:0]      value_q, value_d;

  logic                   has_evt;
  logic                   advance;
  logic                   in_accept;
  logic                   axis_hit;
  logic [IndexW-1:0]      axis_idx;
  logic                   btn_hit;
  logic [IndexW-1:0]      btn_idx;
  logic [ButtonSlots-1:0] btn_diff;

  assign advance    = s1_valid_q && (!has_evt || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      poll_valid_q <= poll_valid_i;
      axis_q[0]    <= axis_x_i;
      axis_q[1]    <= axis_y_i;
      axis_q[2]    <= axis_z_i;
      axis_q[3]    <= axis_r_i;
      axis_q[4]    <= axis_u_i;
      axis_q[5]    <= axis_v_i;
      axis_q[6]    <= hat_angle_i;
      button_q     <= button_bits_i;
    end
  end

  // lowest changed axis
  always_comb begin
    axis_hit = 1'b0;
    axis_idx = '0;
    for (int i = AxisCount - 1; i >= 0; i--) begin
      if (axis_q[i] != axis_store_q[i]) begin
        axis_hit = 1'b1;
        axis_idx = IndexW'(i);
      end
    end
  end

  // lowest changed button
  always_comb begin
    btn_diff = button_q ^ button_store_q;
    btn_hit  = 1'b0;
    btn_idx  = '0;
    for (int i = ButtonCount - 1; i >= 0; i--) begin
      if (btn_diff[i]) begin
        btn_hit = 1'b1;
        btn_idx = IndexW'(i);
      end
    end
  end

  always_comb begin
    has_evt        = 1'b0;
    kind_d         = KindConnect;
    index_d        = '0;
    value_d        = '0;
    link_up_d      = link_up_q;
    axis_store_d   = axis_store_q;
    button_store_d = button_store_q;
    if (poll_valid_q && !link_up_q) begin
      has_evt   = 1'b1;
      kind_d    = KindConnect;
      link_up_d = 1'b1;
    end else if (!poll_valid_q) begin
      if (link_up_q) begin
        has_evt   = 1'b1;
        kind_d    = KindDisconnect;
        link_up_d = 1'b0;
      end
    end else if (axis_hit) begin
      has_evt  = 1'b1;
      kind_d   = KindAxis;
      index_d  = axis_idx;
      value_d  = axis_q[axis_idx[2:0]];
      axis_store_d[axis_idx[2:0]] = axis_q[axis_idx[2:0]];
    end else if (btn_hit) begin
      has_evt  = 1'b1;
      kind_d   = KindButton;
      index_d  = btn_idx;
      value_d  = ValueW'(button_q[btn_idx]);
      button_store_d[btn_idx] = button_q[btn_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_up_q      <= 1'b0;
      axis_store_q   <= '{default: '0};
      button_store_q <= '0;
    end else if (advance) begin
      link_up_q      <= link_up_d;
      axis_store_q   <= axis_store_d;
      button_store_q <= button_store_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && has_evt) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_evt) begin
      kind_q  <= kind_d;
      index_q <= index_d;
      value_q <= value_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = kind_q;
  assign event_index_o = index_q;
  assign event_value_o = value_q;

endmodule

### verif/ccegen_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccegen_checker
// Watches the poll and event channels of the controller change event
// generator. For every accepted poll beat it predicts the event that the
// poll causes, if any, from its own copy of the link flag and the stored
// axes and buttons. Every accepted event beat is compared field by field
// with the oldest predicted event. It reports the failure count and the
// number of events still awaited.
// ----------------------------------------------------------------------------
module ccegen_checker
  import ccegen_pkg::*;
(
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic                              poll_valid_i,
  input  logic [AxisSlots-1:0][AxisW-1:0]   axes_i,
  input  logic [ButtonSlots-1:0]            button_bits_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [KindW-1:0]                  event_kind_i,
  input  logic [IndexW-1:0]                 event_index_i,
  input  logic [ValueW-1:0]                 event_value_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o
);

  typedef struct {
    logic                hit;
    event_kind_e         kind;
    logic [IndexW-1:0]   index;
    logic [ValueW-1:0]   value;
  } change_event_t;

  logic                            link_up;
  logic [AxisSlots-1:0][AxisW-1:0] axis_copy;
  logic [ButtonSlots-1:0]          button_copy;
  change_event_t                   awaited_events[$];
  int unsigned                     fails;

  function automatic change_event_t next_event(
    input logic                            ok,
    input logic [AxisSlots-1:0][AxisW-1:0] axes,
    input logic [ButtonSlots-1:0]          btn
  );
    change_event_t ev;
    ev.hit   = 1'b0;
    ev.kind  = KindConnect;
    ev.index = '0;
    ev.value = '0;
    if (ok && !link_up) begin
      link_up = 1'b1;
      ev.hit  = 1'b1;
      ev.kind = KindConnect;
    end else if (!ok) begin
      if (link_up) begin
        link_up = 1'b0;
        ev.hit  = 1'b1;
        ev.kind = KindDisconnect;
      end
    end else begin
      for (int i = 0; i < AxisCount; i++) begin
        if (!ev.hit && axes[i] != axis_copy[i]) begin
          axis_copy[i] = axes[i];
          ev.hit   = 1'b1;
          ev.kind  = KindAxis;
          ev.index = IndexW'(i);
          ev.value = axes[i];
        end
      end
      for (int i = 0; i < ButtonCount; i++) begin
        if (!ev.hit && btn[i] != button_copy[i]) begin
          button_copy[i] = btn[i];
          ev.hit   = 1'b1;
          ev.kind  = KindButton;
          ev.index = IndexW'(i);
          ev.value = ValueW'(btn[i]);
        end
      end
    end
    return ev;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    change_event_t ev;
    change_event_t want;
    if (!rst_ni) begin
      link_up      = 1'b0;
      axis_copy    = '0;
      button_copy  = '0;
      fails        = 0;
      awaited_events.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // event beats first: an event leaving now belongs to an older poll
      if (out_valid_i && !out_stall_i) begin
        if (awaited_events.size() == 0) begin
          $error("event beat with none expected: kind %0d index %0d value %0d",
                 event_kind_i, event_index_i, event_value_i);
          fails++;
        end else begin
          want = awaited_events.pop_front();
          if (event_kind_i !== want.kind) begin
            $error("event_kind: expected %0d, got %0d", want.kind, event_kind_i);
            fails++;
          end
          if (event_index_i !== want.index) begin
            $error("event_index: expected %0d, got %0d", want.index, event_index_i);
            fails++;
          end
          if (event_value_i !== want.value) begin
            $error("event_value: expected %0d, got %0d", want.value, event_value_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        ev = next_event(poll_valid_i, axes_i, button_bits_i);
        if (ev.hit) awaited_events.push_back(ev);
      end
      fail_count_o <= fails;
      pending_o    <= awaited_events.size();
    end
  end

endmodule

### verif/tb_controller_change_event_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_controller_change_event_generator
// Drives poll beats into the controller change event generator: a directed
// run through connect, disconnect, reconnect, every axis and the edge
// buttons, then random polls that mostly evolve one controller state a few
// fields at a time, with noise and dropped polls mixed in. Sender gaps and
// receiver stalls vary by phase, and one phase holds the receiver off long
// enough to back the block up. Checking is done by ccegen_checker.
// ----------------------------------------------------------------------------
module tb_controller_change_event_generator;
  import ccegen_pkg::*;

  localparam int unsigned QuietLimit  = 3000;
  localparam int unsigned PhaseItems  = 80;
  localparam int unsigned HoldCycles  = 200;

  typedef struct {
    logic                            ok;
    logic [AxisSlots-1:0][AxisW-1:0] axes;
    logic [ButtonSlots-1:0]          buttons;
  } poll_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        poll_valid = 1'b0;
  logic [15:0] axis_x = '0;
  logic [15:0] axis_y = '0;
  logic [15:0] axis_z = '0;
  logic [15:0] axis_r = '0;
  logic [15:0] axis_u = '0;
  logic [15:0] axis_v = '0;
  logic [15:0] hat_angle = '0;
  logic [31:0] button_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  event_kind;
  logic [4:0]  event_index;
  logic [15:0] event_value;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  bit          pressure_on = 1'b0;
  bit          held = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet = 0;

  always #5 clk_i = ~clk_i;

  controller_change_event_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .poll_valid_i  (poll_valid),
    .axis_x_i      (axis_x),
    .axis_y_i      (axis_y),
    .axis_z_i      (axis_z),
    .axis_r_i      (axis_r),
    .axis_u_i      (axis_u),
    .axis_v_i      (axis_v),
    .hat_angle_i   (hat_angle),
    .button_bits_i (button_bits),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .event_kind_o  (event_kind),
    .event_index_o (event_index),
    .event_value_o (event_value)
  );

  ccegen_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .poll_valid_i  (poll_valid),
    .axes_i        ({hat_angle, axis_v, axis_u, axis_r, axis_z, axis_y, axis_x}),
    .button_bits_i (button_bits),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .event_kind_i  (event_kind),
    .event_index_i (event_index),
    .event_value_i (event_value),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // receiver side, with one long hold-off in the pressure phase
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (pressure_on && !held) begin
        held      = 1'b1;
        hold_left = HoldCycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QuietLimit) begin
          $display("tb_controller_change_event_generator: done, errors");
          $finish;
        end
      end
    end
  end

  task automatic send_poll(input poll_t p);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    poll_valid  <= p.ok;
    axis_x      <= p.axes[0];
    axis_y      <= p.axes[1];
    axis_z      <= p.axes[2];
    axis_r      <= p.axes[3];
    axis_u      <= p.axes[4];
    axis_v      <= p.axes[5];
    hat_angle   <= p.axes[6];
    button_bits <= p.buttons;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  function automatic logic [AxisW-1:0] pick_axis();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return AxisW'($urandom_range(3));
      default: return AxisW'($urandom());
    endcase
  endfunction

  initial begin : stimulus
    poll_t pad;
    poll_t p;
    int unsigned r;
    int unsigned n;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // dropped polls while down, connect, no change
    p.ok = 1'b0; p.axes = '0; p.buttons = '0;
    send_poll(p);
    p.axes = '1; p.buttons = '1;
    send_poll(p);
    p.ok = 1'b1; p.axes = '0; p.buttons = '0;
    send_poll(p);
    send_poll(p);
    // every axis at full scale, then the lowest button
    p.axes = '1; p.buttons = '1;
    for (int i = 0; i < 8; i++) send_poll(p);
    // disconnect, then reconnect keeps the stored snapshot
    p.ok = 1'b0;
    send_poll(p);
    p.ok = 1'b1; p.axes = '0; p.buttons = 32'h8000_0001;
    for (int i = 0; i < 9; i++) send_poll(p);
    p.buttons = '0;
    send_poll(p);
    p.axes[6] = '1;
    send_poll(p);

    pad = p;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 64; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 64; end
        3: begin tx_idle_pct = 32; rx_stall_pct = 32; end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
          pressure_on  = 1'b1;
        end
      endcase
      for (int k = 0; k < PhaseItems; k++) begin
        r = $urandom_range(99);
        if (r < 8) begin
          p.ok      = 1'b0;
          p.buttons = $urandom();
          for (int a = 0; a < AxisSlots; a++) p.axes[a] = pick_axis();
        end else begin
          if (r < 18) begin
            pad.buttons = $urandom();
            for (int a = 0; a < AxisSlots; a++) pad.axes[a] = pick_axis();
          end else if ($urandom_range(1) == 0) begin
            n = $urandom_range(3, 1);
            for (int c = 0; c < n; c++) begin
              if ($urandom_range(2) == 0)
                pad.axes[$urandom_range(AxisSlots - 1)] = pick_axis();
              else
                pad.buttons[$urandom_range(ButtonSlots - 1)] ^= 1'b1;
            end
          end
          p    = pad;
          p.ok = 1'b1;
        end
        send_poll(p);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_controller_change_event_generator: done, clean");
    end else begin
      $display("tb_controller_change_event_generator: done, errors");
    end
    $finish;
  end

endmodule
